/* hw/rtl/clock_rate_ratio_monitor_assert.svh */
// Assertion macros used by the checker file.
`ifndef CLOCK_RATE_RATIO_MONITOR_ASSERT_SVH
`define CLOCK_RATE_RATIO_MONITOR_ASSERT_SVH
`define CRRM_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CRRM_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

/* hw/rtl/crrm_pkg.sv */
`default_nettype none
package crrm_pkg;
   typedef enum logic [2:0] {
      REG_ENABLE   = 3'd0,
      REG_WINDOW   = 3'd1,
      REG_MAX_GAP  = 3'd2,
      REG_MIN_SAMP = 3'd3,
      REG_TOL      = 3'd4,
      REG_SUSTAIN  = 3'd5,
      REG_COOLDOWN = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_UPDATE,
      ST_COMPARE,
      ST_DIV_Q,
      ST_DIV_S,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic        fire;
      logic [6:0]  severity;
      logic [31:0] ratio_q16;
   } result_type;
endpackage
`default_nettype wire

/* hw/rtl/crrm_req_if.sv */
`default_nettype none
interface crrm_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] claimed_time;
   logic [31:0] arrival_time;
   modport source (output valid, output claimed_time, output arrival_time, input ready);
   modport sink (input valid, input claimed_time, input arrival_time, output ready);
endinterface
`default_nettype wire

/* hw/rtl/crrm_rsp_if.sv */
`default_nettype none
interface crrm_rsp_if;
   logic        valid;
   logic        ready;
   logic        fire;
   logic [6:0]  severity;
   logic [31:0] ratio_q16;
   modport source (output valid, output fire, output severity, output ratio_q16, input ready);
   modport sink (input valid, input fire, input severity, input ratio_q16, output ready);
endinterface
`default_nettype wire

/* hw/rtl/clock_rate_ratio_monitor.sv */
// Clock-rate ratio monitor. Each transaction on the request channel carries a claimed remote time
// and a local arrival time; exactly one response transaction follows. The sample ring lies in a
// single-port-read RAM of MAX_WINDOW entries rounded up to a power of two, which is swept clear
// entry by entry after reset and after every write of window_len; no request is taken meanwhile.
// A taken request steps through the read, update, compare and finish states when enabled, and on
// a fire the bit-serial divider then forms first the ratio and then the severity; when disabled,
// the response is offered with no sample update. A new request can be taken in the cycle after
// the previous response has been handed over, unless a window_len write awaits its sweep.
// Registers are written and read over the APB port at byte address 4*i.
`default_nettype none
module clock_rate_ratio_monitor #(
   parameter int unsigned MAX_WINDOW = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   crrm_req_if.sink         req,
   crrm_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import crrm_pkg::*;

   localparam int unsigned AddrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SumW  = 32 + AddrW;
   localparam int unsigned ProdW = SumW + 11;
   localparam int unsigned DivW  = SumW + 16;
   localparam int unsigned DivCntW = $clog2(DivW + 1);

   logic        enable_ff;
   logic [6:0]  window_len_ff;
   logic [31:0] max_gap_ff;
   logic [6:0]  min_samples_ff;
   logic [9:0]  tol_ff;
   logic [15:0] sustain_ff;
   logic [31:0] cooldown_ff;

   state_type state_ff, state_in;

   logic [AddrW-1:0]    head_ff, clr_ff, slot_ff;
   logic [CntW-1:0]     fill_ff, valid_cnt_ff, w_eff;
   logic [SumW-1:0]     sum_c_ff, sum_r_ff;
   logic                have_prev_ff;
   logic [31:0]         prev_c_ff, prev_a_ff;
   logic [31:0]         streak_ff;
   logic                cooling_ff;
   logic [31:0]         deadline_ff;
   logic [31:0]         arrival_ff;
   logic                s_valid_ff;
   logic [31:0]         s_cd_ff, s_rd_ff;
   logic                wipe_ff;

   logic [ProdW-1:0]    lhs_hot_ff, rhs_hot_ff, lhs_cool_ff, rhs_cool_ff;

   logic [DivW-1:0]     dividend_ff, rem_ff, divisor_ff;
   logic [DivCntW-1:0]  div_cnt_ff;
   logic [31:0]         ratio_ff;
   result_type          result_ff;

   logic                cfg_wr;
   logic                take;
   logic                ram_we;
   logic [AddrW-1:0]    ram_wa;
   logic [64:0]         ram_wd, ram_rd;
   logic [DivW:0]       rem_shift;
   logic                evaluate, hot, cool, fire_now;
   logic [31:0]         streak_n;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[4:2])
         REG_ENABLE:   csr_prdata = {31'd0, enable_ff};
         REG_WINDOW:   csr_prdata = {25'd0, window_len_ff};
         REG_MAX_GAP:  csr_prdata = max_gap_ff;
         REG_MIN_SAMP: csr_prdata = {25'd0, min_samples_ff};
         REG_TOL:      csr_prdata = {22'd0, tol_ff};
         REG_SUSTAIN:  csr_prdata = {16'd0, sustain_ff};
         REG_COOLDOWN: csr_prdata = cooldown_ff;
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (window_len_ff == 7'd0) begin
         w_eff = CntW'(1);
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         w_eff = CntW'(MAX_WINDOW);
      end else begin
         w_eff = CntW'(window_len_ff);
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !wipe_ff && !(rsp.valid);
   assign take = req.valid && req.ready;
   assign rsp.valid = (state_ff == ST_OUTPUT);
   assign rsp.fire = result_ff.fire;
   assign rsp.severity = result_ff.severity;
   assign rsp.ratio_q16 = result_ff.ratio_q16;

   assign ram_we = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
   assign ram_wa = (state_ff == ST_CLEAR) ? clr_ff : slot_ff;
   assign ram_wd = (state_ff == ST_CLEAR) ? '0 : {s_valid_ff, s_cd_ff, s_rd_ff};

   crrm_ram #(.Width(65), .Depth(2 ** AddrW)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (slot_ff),
      .rd_data (ram_rd)
   );

   assign rem_shift = {rem_ff, dividend_ff[DivW-1]};

   always_comb begin
      evaluate = (32'(valid_cnt_ff) >= 32'(min_samples_ff)) && (sum_r_ff != '0);
      hot = lhs_hot_ff >= rhs_hot_ff;
      cool = lhs_cool_ff < rhs_cool_ff;
      streak_n = streak_ff;
      if (hot) begin
         if (streak_ff != 32'hFFFF_FFFF) streak_n = streak_ff + 32'd1;
      end else if (cool) begin
         streak_n = '0;
      end
      fire_now = evaluate && (streak_n >= 32'(sustain_ff)) && !cooling_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (wipe_ff) state_in = ST_CLEAR;
                     else if (take) state_in = enable_ff ? ST_READ : ST_OUTPUT;
         ST_CLEAR:   if (32'(clr_ff) == MAX_WINDOW - 1) state_in = ST_IDLE;
         ST_READ:    state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_FINISH;
         ST_FINISH:  state_in = fire_now ? ST_DIV_Q : ST_OUTPUT;
         ST_DIV_Q:   if (div_cnt_ff == DivCntW'(DivW)) state_in = ST_DIV_S;
         ST_DIV_S:   if (div_cnt_ff == DivCntW'(DivW)) state_in = ST_OUTPUT;
         ST_OUTPUT:  if (rsp.ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      logic [31:0] cd, rd;
      logic        drop;
      logic [SumW-1:0] sc, sr;
      logic [CntW-1:0] vc;
      logic [32:0] lim;
      if (reset) begin
         state_ff <= ST_CLEAR;
         wipe_ff <= 1'b0;
         clr_ff <= '0;
         enable_ff <= 1'b0;
         window_len_ff <= 7'd1;
         max_gap_ff <= '0;
         min_samples_ff <= '0;
         tol_ff <= '0;
         sustain_ff <= '0;
         cooldown_ff <= '0;
         head_ff <= '0;
         fill_ff <= '0;
         valid_cnt_ff <= '0;
         sum_c_ff <= '0;
         sum_r_ff <= '0;
         have_prev_ff <= 1'b0;
         prev_c_ff <= '0;
         prev_a_ff <= '0;
         streak_ff <= '0;
         cooling_ff <= 1'b0;
         deadline_ff <= '0;
         result_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            unique case (csr_paddr[4:2])
               REG_ENABLE:   enable_ff <= csr_pwdata[0];
               REG_WINDOW: begin
                  window_len_ff <= csr_pwdata[6:0];
                  wipe_ff <= 1'b1;
                  head_ff <= '0;
                  fill_ff <= '0;
                  valid_cnt_ff <= '0;
                  sum_c_ff <= '0;
                  sum_r_ff <= '0;
               end
               REG_MAX_GAP:  max_gap_ff <= csr_pwdata;
               REG_MIN_SAMP: min_samples_ff <= csr_pwdata[6:0];
               REG_TOL:      tol_ff <= csr_pwdata[9:0];
               REG_SUSTAIN:  sustain_ff <= csr_pwdata[15:0];
               REG_COOLDOWN: cooldown_ff <= csr_pwdata;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (wipe_ff) begin
                  wipe_ff <= 1'b0;
                  clr_ff <= '0;
               end else if (take) begin
                  result_ff <= '0;
                  if (enable_ff) begin
                     cd = req.claimed_time - prev_c_ff;
                     rd = req.arrival_time - prev_a_ff;
                     lim = {1'b0, rd} + {1'b0, max_gap_ff};
                     drop = (rd == 32'd0) ||
                            ((max_gap_ff != 32'd0) && (rd > max_gap_ff)) ||
                            ((max_gap_ff != 32'd0) && ({1'b0, cd} > lim));
                     s_valid_ff <= have_prev_ff && !drop;
                     s_cd_ff <= (have_prev_ff && !drop) ? cd : 32'd0;
                     s_rd_ff <= (have_prev_ff && !drop) ? rd : 32'd0;
                     prev_c_ff <= req.claimed_time;
                     prev_a_ff <= req.arrival_time;
                     have_prev_ff <= 1'b1;
                     arrival_ff <= req.arrival_time;
                     slot_ff <= (CntW'(head_ff) >= w_eff) ? '0 : head_ff;
                  end
               end
            end
            ST_CLEAR: clr_ff <= clr_ff + AddrW'(1);
            ST_UPDATE: begin
               sc = sum_c_ff;
               sr = sum_r_ff;
               vc = valid_cnt_ff;
               if (fill_ff >= w_eff) begin
                  if (ram_rd[64]) begin
                     sc = sc - SumW'(ram_rd[63:32]);
                     sr = sr - SumW'(ram_rd[31:0]);
                     if (vc != '0) vc = vc - CntW'(1);
                  end
               end else begin
                  fill_ff <= fill_ff + CntW'(1);
               end
               if (s_valid_ff) begin
                  sc = sc + SumW'(s_cd_ff);
                  sr = sr + SumW'(s_rd_ff);
                  vc = vc + CntW'(1);
               end
               sum_c_ff <= sc;
               sum_r_ff <= sr;
               valid_cnt_ff <= vc;
               head_ff <= (CntW'(slot_ff) + CntW'(1) >= w_eff) ? '0 : slot_ff + AddrW'(1);
               if (cooling_ff && !(arrival_ff - deadline_ff >= 32'h8000_0000))
                  cooling_ff <= 1'b0;
            end
            ST_COMPARE: begin
               lhs_hot_ff <= ProdW'(sum_c_ff) * 7'd100;
               rhs_hot_ff <= ProdW'(sum_r_ff) * (11'd100 + 11'(tol_ff));
               lhs_cool_ff <= ProdW'(sum_c_ff) * 8'd200;
               rhs_cool_ff <= ProdW'(sum_r_ff) * (11'd200 + 11'(tol_ff));
            end
            ST_FINISH: begin
               if (evaluate) streak_ff <= fire_now ? 32'd0 : streak_n;
               if (fire_now) begin
                  cooling_ff <= 1'b1;
                  deadline_ff <= arrival_ff + cooldown_ff;
                  dividend_ff <= DivW'({sum_c_ff, 16'd0});
                  divisor_ff <= DivW'(sum_r_ff);
                  rem_ff <= '0;
                  div_cnt_ff <= '0;
               end
            end
            ST_DIV_Q, ST_DIV_S: begin
               if (div_cnt_ff == DivCntW'(DivW)) begin
                  if (state_ff == ST_DIV_Q) begin
                     ratio_ff <= (dividend_ff[DivW-1:32] != '0) ? 32'hFFFF_FFFF
                                 : dividend_ff[31:0];
                     dividend_ff <= (sum_c_ff > sum_r_ff)
                        ? DivW'((sum_c_ff - sum_r_ff) * 8'd200 + (SumW+8)'(sum_r_ff))
                        : '0;
                     divisor_ff <= DivW'({sum_r_ff, 1'b0});
                     rem_ff <= '0;
                     div_cnt_ff <= '0;
                  end else begin
                     result_ff.fire <= 1'b1;
                     result_ff.ratio_q16 <= ratio_ff;
                     if (dividend_ff > DivW'(100)) result_ff.severity <= 7'd100;
                     else if (dividend_ff == '0) result_ff.severity <= 7'd1;
                     else result_ff.severity <= dividend_ff[6:0];
                  end
               end else begin
                  if (rem_shift >= {1'b0, divisor_ff}) begin
                     rem_ff <= DivW'(rem_shift - {1'b0, divisor_ff});
                     dividend_ff <= {dividend_ff[DivW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_shift[DivW-1:0];
                     dividend_ff <= {dividend_ff[DivW-2:0], 1'b0};
                  end
                  div_cnt_ff <= div_cnt_ff + DivCntW'(1);
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/crrm_ram.sv */
`default_nettype none
module crrm_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/crrm_checker.sv */
`default_nettype none
`include "clock_rate_ratio_monitor_assert.svh"
module crrm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_fire,
   input wire logic [6:0]  rsp_severity,
   input wire logic [31:0] rsp_ratio_q16
);
   `CRRM_ASSERT_IMPL(a_quiet_when_idle, clock, reset,
      (rsp_valid && !rsp_fire) |-> (rsp_severity == 7'd0 && rsp_ratio_q16 == 32'd0))
   `CRRM_ASSERT_IMPL(a_sev_range, clock, reset,
      (rsp_valid && rsp_fire) |-> (rsp_severity >= 7'd1 && rsp_severity <= 7'd100))
   `CRRM_ASSERT_IMPL(a_no_take_while_busy, clock, reset, rsp_valid |-> !req_ready)
   `CRRM_ASSERT_NEXT(a_one_at_a_time, clock, reset, (req_valid && req_ready), !req_ready)
endmodule

bind clock_rate_ratio_monitor crrm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_fire      (rsp.fire),
   .rsp_severity  (rsp.severity),
   .rsp_ratio_q16 (rsp.ratio_q16)
);
`default_nettype wire

/* dv/clock_rate_ratio_monitor_test.sv */
`timescale 1ns / 100ps
`default_nettype none

module clock_rate_ratio_monitor_test;
   import crrm_pkg::*;

   class ratio_scoreboard;
      bit          enable_q;
      logic [6:0]  window_q;
      logic [31:0] max_gap_q;
      logic [6:0]  min_samples_q;
      logic [9:0]  tolerance_q;
      logic [15:0] sustain_q;
      logic [31:0] cooldown_q;
      bit          slot_valid [64];
      logic [31:0] slot_cd [64];
      logic [31:0] slot_rd [64];
      int unsigned head;
      int unsigned fill;
      int unsigned valid_pairs;
      logic [63:0] claimed_sum;
      logic [63:0] real_sum;
      bit          have_prev;
      logic [31:0] prev_claimed;
      logic [31:0] prev_arrival;
      logic [31:0] streak;
      bit          cooling;
      logic [31:0] deadline;
      result_type  pending [$];
      int          errors;

      function new();
         enable_q = 0;
         window_q = 1;
         max_gap_q = 0;
         min_samples_q = 0;
         tolerance_q = 0;
         sustain_q = 0;
         cooldown_q = 0;
         clear_ring();
         have_prev = 0;
         prev_claimed = 0;
         prev_arrival = 0;
         streak = 0;
         cooling = 0;
         deadline = 0;
         errors = 0;
      endfunction

      function void clear_ring();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 0;
            slot_cd[i] = 0;
            slot_rd[i] = 0;
         end
         head = 0;
         fill = 0;
         valid_pairs = 0;
         claimed_sum = 0;
         real_sum = 0;
      endfunction

      function void write_register(reg_index_type index, logic [31:0] value);
         case (index)
            REG_ENABLE: enable_q = value[0];
            REG_WINDOW: begin
               window_q = value[6:0];
               clear_ring();
            end
            REG_MAX_GAP: max_gap_q = value;
            REG_MIN_SAMP: min_samples_q = value[6:0];
            REG_TOL: tolerance_q = value[9:0];
            REG_SUSTAIN: sustain_q = value[15:0];
            REG_COOLDOWN: cooldown_q = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic [31:0] claimed, logic [31:0] arrival);
         result_type  res;
         bit          ok;
         logic [31:0] cd;
         logic [31:0] rd;
         int unsigned w;
         int unsigned h;
         logic [63:0] c;
         logic [63:0] r;
         logic [63:0] sev;
         logic [63:0] q;
         logic [31:0] since;
         res = '0;
         if (enable_q) begin
            ok = 0;
            cd = claimed - prev_claimed;
            rd = arrival - prev_arrival;
            if (have_prev) begin
               ok = !(rd == 0 || (max_gap_q != 0 && rd > max_gap_q)
                  || (max_gap_q != 0 && {32'd0, cd} > {32'd0, rd} + {32'd0, max_gap_q}));
            end
            if (!ok) begin
               cd = 0;
               rd = 0;
            end
            prev_claimed = claimed;
            prev_arrival = arrival;
            have_prev = 1;
            w = window_q;
            if (w < 1) w = 1;
            if (w > 64) w = 64;
            h = head;
            if (h >= w) h = 0;
            if (fill >= w) begin
               if (slot_valid[h]) begin
                  claimed_sum -= slot_cd[h];
                  real_sum -= slot_rd[h];
                  if (valid_pairs > 0) valid_pairs--;
               end
            end else begin
               fill++;
            end
            slot_valid[h] = ok;
            slot_cd[h] = cd;
            slot_rd[h] = rd;
            head = (h + 1 >= w) ? 0 : h + 1;
            if (ok) begin
               claimed_sum += cd;
               real_sum += rd;
               valid_pairs++;
            end
            since = arrival - deadline;
            if (cooling && !since[31]) cooling = 0;
            if (valid_pairs >= min_samples_q && real_sum != 0) begin
               c = claimed_sum;
               r = real_sum;
               if (100 * c >= (100 + tolerance_q) * r) begin
                  if (streak != 32'hFFFF_FFFF) streak++;
               end else if (200 * c < (200 + tolerance_q) * r) begin
                  streak = 0;
               end
               if (streak >= sustain_q && !cooling) begin
                  sev = 1;
                  if (c > r) begin
                     sev = (200 * (c - r) + r) / (2 * r);
                     if (sev < 1) sev = 1;
                     if (sev > 100) sev = 100;
                  end
                  q = (c << 16) / r;
                  if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
                  res.fire = 1;
                  res.severity = sev[6:0];
                  res.ratio_q16 = q[31:0];
                  streak = 0;
                  cooling = 1;
                  deadline = arrival + cooldown_q;
               end
            end
         end
         pending.push_back(res);
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.fire !== want.fire) begin
            $display("%0t: fire expected %b actual %b", $time, want.fire, got.fire);
            errors++;
         end
         if (got.severity !== want.severity) begin
            $display("%0t: severity expected %0d actual %0d", $time, want.severity,
               got.severity);
            errors++;
         end
         if (got.ratio_q16 !== want.ratio_q16) begin
            $display("%0t: ratio expected %h actual %h", $time, want.ratio_q16,
               got.ratio_q16);
            errors++;
         end
      endfunction
   endclass

   localparam int WatchdogLimit = 20000;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   crrm_req_if req ();
   crrm_rsp_if rsp ();

   clock_rate_ratio_monitor dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   ratio_scoreboard board = new();
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          recv_hold;
   int          quiet_cycles;
   logic [31:0] claimed_clock;
   logic [31:0] arrival_clock;

   initial begin
      clock = 0;
   end

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
         if (rsp.valid && rsp.ready) begin
            board.check_response('{rsp.fire, rsp.severity, rsp.ratio_q16});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Registers are only written once every outstanding transaction has completed.
   task automatic write_register(reg_index_type index, logic [31:0] value);
      while (board.pending.size() != 0) @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 5'(index) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      board.write_register(index, value);
      @(posedge clock);
   endtask

   task automatic send_pair(logic [31:0] claimed, logic [31:0] arrival);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req.valid <= 1;
      req.claimed_time <= claimed;
      req.arrival_time <= arrival;
      do @(posedge clock); while (!req.ready);
      board.note_request(claimed, arrival);
      req.valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Steady traffic with a chosen rate ratio in percent, with occasional jitter and glitches.
   task automatic send_run(int count, int rate_pct, int noise_pct);
      int step;
      for (int i = 0; i < count; i++) begin
         step = $urandom_range(1, 40);
         arrival_clock += step;
         claimed_clock += (step * rate_pct) / 100 + $urandom_range(1);
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(3))
               0: send_pair($urandom, $urandom);
               1: send_pair(claimed_clock, arrival_clock - step);
               2: send_pair(claimed_clock + $urandom_range(5000), arrival_clock);
               default: send_pair(claimed_clock, arrival_clock + $urandom_range(9000));
            endcase
         end else begin
            send_pair(claimed_clock, arrival_clock);
         end
      end
   endtask

   task automatic random_settings();
      write_register(REG_WINDOW, $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(127));
      write_register(REG_MAX_GAP, $urandom_range(3) == 0 ? 0 : $urandom_range(20, 2000));
      write_register(REG_MIN_SAMP, $urandom_range(6));
      write_register(REG_TOL, $urandom_range(3) == 0 ? $urandom_range(1023) :
         $urandom_range(60));
      write_register(REG_SUSTAIN, $urandom_range(4));
      write_register(REG_COOLDOWN, $urandom_range(1) ? $urandom_range(300) : $urandom);
      write_register(REG_ENABLE, $urandom_range(9) != 0);
   endtask

   initial begin
      reset = 1;
      recv_hold = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      quiet_cycles = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      req.valid = 0;
      req.claimed_time = 0;
      req.arrival_time = 0;
      claimed_clock = 32'hFFFF_F000;
      arrival_clock = 32'hFFFF_F800;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_register(REG_ENABLE, 1);
      write_register(REG_WINDOW, 0);
      send_pair(0, 0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(100, 100);
      send_pair(100, 100);
      send_pair(32'hFFFF_FFFF, 200);
      write_register(REG_WINDOW, 127);
      write_register(REG_MAX_GAP, 32'hFFFF_FFFF);
      write_register(REG_MIN_SAMP, 64);
      write_register(REG_TOL, 1023);
      write_register(REG_SUSTAIN, 16'hFFFF);
      write_register(REG_COOLDOWN, 32'hFFFF_FFFF);
      send_pair(0, 0);
      send_pair(32'hFFFF_FFFF, 1);
      drain();
      write_register(REG_WINDOW, 4);
      write_register(REG_MAX_GAP, 50);
      write_register(REG_MIN_SAMP, 0);
      write_register(REG_TOL, 0);
      write_register(REG_SUSTAIN, 0);
      write_register(REG_COOLDOWN, 0);
      send_pair(1000, 1000);
      send_pair(1010, 1010);
      send_pair(1015, 1020);
      send_pair(1200, 1030);
      send_pair(1300, 1100);
      send_pair(1340, 1120);
      send_pair(1340, 1120);
      send_pair(1400, 1130);
      send_pair(1400, 1129);
      drain();
      write_register(REG_MAX_GAP, 0);
      write_register(REG_COOLDOWN, 32'h8000_0000);
      send_pair(0, 0);
      send_pair(32'hFFFF_FFFF, 1);
      send_pair(32'hFFFF_FFFE, 2);
      drain();
      write_register(REG_ENABLE, 0);
      write_register(REG_ENABLE, 1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 28 : (phase == 1 ? 67 : 0);
         recv_idle_pct = phase == 0 ? 67 : (phase == 1 ? 28 : 0);
         for (int run = 0; run < 9; run++) begin
            random_settings();
            send_run(45, $urandom_range(1) ? $urandom_range(90, 110) :
               $urandom_range(100, 400), $urandom_range(15));
            if (run == 4 && phase == 2) begin
               fork
                  begin
                     recv_hold <= 1;
                     repeat (600) @(posedge clock);
                     recv_hold <= 0;
                  end
                  send_run(5, 150, 0);
               join
            end
            drain();
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
